/* hdl/command_frame_parser_assert.svh */
// Assertion macros shared by the frame parser modules.
// Every macro expects clk_i and rst_ni in scope.
`ifndef COMMAND_FRAME_PARSER_ASSERT_SVH
`define COMMAND_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication
`define CFP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CFP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/cfp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cfp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CODE_W     = 2;
  localparam int unsigned TRACK_W    = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_HEADER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOWNSTRM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REMOTE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_FUNC  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_DEV   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_TRACK = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_LIMIT = 3'd7;

  // Special byte values
  localparam logic [BYTE_W-1:0] CHECK_WILDCARD = 8'hFF;
  localparam logic [BYTE_W-1:0] BROADCAST      = 8'h00;
  localparam logic [CODE_W-1:0] CODE_BCAST     = 2'd0;

  typedef struct packed {
    logic [BYTE_W-1:0]  header_value;
    logic [BYTE_W-1:0]  tail_value;
    logic [CODE_W-1:0]  downstream_code;
    logic [CODE_W-1:0]  remote_code;
    logic [CODE_W-1:0]  own_function_code;
    logic [CODE_W-1:0]  own_device;
    logic [TRACK_W-1:0] own_track;
    logic [BYTE_W-1:0]  command_limit;
  } cfg_t;

endpackage

`default_nettype wire

/* hdl/command_frame_parser.sv */
// Channel   Dir  Handshake              Payload
// ------    ---  ---------------------  ------------------------------
// input     in   in_valid_i/in_stall_o  rx_byte_i
// output    out  out_valid_o/out_stall_i frame_ok_o, command_byte_o
// config    in   cfg_we_i               cfg_index_i, cfg_data_i
//
// One byte per cycle unless the input stalls; a taken byte goes into the
// input register, then through the parse logic into the result register.
// Reset sets the frame state to hunting and zeroes valid flags and config.
// A stalled output holds its beat; the input stalls only when the input
// register holds a beat and the result register is full and stalled.
`timescale 1ns / 1ps
`default_nettype none

module command_frame_parser
  import cfp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [BYTE_W-1:0]     rx_byte_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       frame_ok_o,
  output logic [BYTE_W-1:0]          command_byte_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t              cfg;
  logic              s1_valid_q, s1_valid_d;
  logic [BYTE_W-1:0] s1_byte_q;
  logic              out_valid_q, out_valid_d;
  logic              ok_q;
  logic [BYTE_W-1:0] cmd_q;
  logic              out_free;
  logic              s1_move;
  logic              in_take;
  logic              ok_c;
  logic [BYTE_W-1:0] cmd_c;

  cfp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Beat flow between the two register stages
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_take || (s1_valid_q && !s1_move);
  assign out_valid_d = s1_move || (out_valid_q && out_stall_i);

  cfp_frame_fsm u_fsm (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (s1_move),
    .byte_i         (s1_byte_q),
    .cfg_i          (cfg),
    .frame_ok_o     (ok_c),
    .command_byte_o (cmd_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= rx_byte_i;
    end
    if (s1_move) begin
      ok_q  <= ok_c;
      cmd_q <= cmd_c;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_ok_o     = ok_q;
  assign command_byte_o = cmd_q;

`include "command_frame_parser_assert.svh"

  `CFP_ASSERT_IMP(a_stall_when_full, in_stall_o, s1_valid_q && out_valid_q, "input stalled with room to spare")
  `CFP_ASSERT_NXT(a_move_fills_out, s1_move, out_valid_q, "moved beat missing from result register")
  `CFP_ASSERT_IMP(a_cmd_zero_no_frame, out_valid_q && !ok_q, cmd_q == BROADCAST, "command byte set without a frame")

endmodule

`default_nettype wire

/* hdl/cfp_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module cfp_cfg_regs
  import cfp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_HEADER:    cfg_d.header_value      = cfg_data_i;
        REG_TAIL:      cfg_d.tail_value        = cfg_data_i;
        REG_DOWNSTRM:  cfg_d.downstream_code   = cfg_data_i[CODE_W-1:0];
        REG_REMOTE:    cfg_d.remote_code       = cfg_data_i[CODE_W-1:0];
        REG_OWN_FUNC:  cfg_d.own_function_code = cfg_data_i[CODE_W-1:0];
        REG_OWN_DEV:   cfg_d.own_device        = cfg_data_i[CODE_W-1:0];
        REG_OWN_TRACK: cfg_d.own_track         = cfg_data_i[TRACK_W-1:0];
        REG_CMD_LIMIT: cfg_d.command_limit     = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* hdl/cfp_frame_fsm.sv */
`timescale 1ns / 1ps
`default_nettype none

module cfp_frame_fsm
  import cfp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire logic [BYTE_W-1:0] byte_i,
  input  cfg_t                   cfg_i,
  output logic                   frame_ok_o,
  output logic [BYTE_W-1:0]      command_byte_o
);

  // Frame positions
  localparam logic [2:0] POS_HUNT  = 3'd0;
  localparam logic [2:0] POS_ADDR  = 3'd1;
  localparam logic [2:0] POS_TRACK = 3'd2;
  localparam logic [2:0] POS_CMD   = 3'd3;
  localparam logic [2:0] POS_FREE0 = 3'd4;
  localparam logic [2:0] POS_FREE1 = 3'd5;
  localparam logic [2:0] POS_TAIL  = 3'd6;
  localparam logic [2:0] POS_CHECK = 3'd7;

  logic [2:0]        pos_q, pos_d;
  logic [BYTE_W-1:0] xor_q, xor_d;
  logic [BYTE_W-1:0] held_q, held_d;
  logic              addr_match;
  logic              track_match;
  logic [CODE_W-1:0] f_dir, f_fn, f_ctl, f_dev;

  // Address byte fields, high to low: direction, function, control, device
  assign f_dir = byte_i[7:6];
  assign f_fn  = byte_i[5:4];
  assign f_ctl = byte_i[3:2];
  assign f_dev = byte_i[1:0];

  assign addr_match = (f_dir == cfg_i.downstream_code)
                   && ((f_fn == cfg_i.own_function_code) || (f_fn == CODE_BCAST))
                   && (f_ctl == cfg_i.remote_code)
                   && ((f_dev == cfg_i.own_device) || (f_dev == CODE_BCAST));

  // Bit 7 set never matches the 7-bit track
  assign track_match = (byte_i == {1'b0, cfg_i.own_track}) || (byte_i == BROADCAST);

  // Next position, checksum and result
  always_comb begin
    pos_d          = pos_q;
    xor_d          = xor_q ^ byte_i;
    held_d         = held_q;
    frame_ok_o     = 1'b0;
    command_byte_o = '0;
    case (pos_q)
      POS_HUNT: begin
        xor_d = xor_q;
        if (byte_i == cfg_i.header_value) begin
          xor_d = byte_i;
          pos_d = POS_ADDR;
        end
      end
      POS_ADDR:  pos_d = addr_match ? POS_TRACK : POS_HUNT;
      POS_TRACK: pos_d = track_match ? POS_CMD : POS_HUNT;
      POS_CMD: begin
        if (byte_i < cfg_i.command_limit) begin
          held_d = byte_i;
          pos_d  = POS_FREE0;
        end else begin
          pos_d = POS_HUNT;
        end
      end
      POS_FREE0: pos_d = POS_FREE1;
      POS_FREE1: pos_d = POS_TAIL;
      POS_TAIL:  pos_d = (byte_i == cfg_i.tail_value) ? POS_CHECK : POS_HUNT;
      POS_CHECK: begin
        xor_d = xor_q;
        pos_d = POS_HUNT;
        if ((byte_i == xor_q) || (byte_i == CHECK_WILDCARD)) begin
          frame_ok_o     = 1'b1;
          command_byte_o = held_q;
        end
      end
      default: pos_d = POS_HUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_HUNT;
      xor_q <= '0;
    end else if (fire_i) begin
      pos_q <= pos_d;
      xor_q <= xor_d;
    end
  end

  // Command hold: always written before it is read
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      held_q <= held_d;
    end
  end

`include "command_frame_parser_assert.svh"

  `CFP_ASSERT_NXT(a_check_rehunts, fire_i && (pos_q == POS_CHECK), pos_q == POS_HUNT, "checksum beat did not return to hunt")
  `CFP_ASSERT_IMP(a_ok_only_at_check, frame_ok_o, pos_q == POS_CHECK, "frame flagged outside checksum position")

endmodule

`default_nettype wire

/* verif/command_frame_parser_tb.sv */
`timescale 1ns / 1ps

module command_frame_parser_tb;
  import cfp_pkg::*;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int HOLD_CYCLES  = 50;
  localparam int IDLE_PERCENT = 18;

  typedef struct packed {
    logic              frame_ok;
    logic [BYTE_W-1:0] command_byte;
  } verdict_t;

  typedef enum {CHK_EXACT, CHK_WILD, CHK_BAD} check_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [BYTE_W-1:0]     rx_byte_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  frame_ok_o;
  logic [BYTE_W-1:0]     command_byte_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Stimulus and scoreboard state
  logic [BYTE_W-1:0] bytes_to_send [$];
  verdict_t          frame_verdicts [$];
  logic              in_taken = 1'b0;
  int                bytes_taken = 0;
  int                bytes_queued = 0;
  int                fail_count = 0;
  int                cycle_count = 0;
  int                hold_left = 0;
  int                next_hold_at = 300;

  // Shadow of the parser: register copy and frame state
  cfg_t              shadow_cfg = '0;
  logic [2:0]        frame_pos = '0;
  logic [BYTE_W-1:0] xor_acc = '0;
  logic [BYTE_W-1:0] held_cmd = '0;

  command_frame_parser DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_ok_o     (frame_ok_o),
    .command_byte_o (command_byte_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // No idling on either side while this window of beats goes through
  function automatic logic may_idle();
    return (bytes_taken < 500 || bytes_taken >= 700) && ($urandom_range(99) < IDLE_PERCENT);
  endfunction

  // Advance the frame state by one byte and give the verdict for it
  function automatic verdict_t parse_byte(input logic [BYTE_W-1:0] b);
    verdict_t v;
    v = '0;
    case (frame_pos)
      3'd0: begin
        if (b == shadow_cfg.header_value) begin
          xor_acc   = b;
          frame_pos = 3'd1;
        end
      end
      3'd1: begin
        xor_acc ^= b;
        frame_pos = (b[7:6] == shadow_cfg.downstream_code
                     && (b[5:4] == shadow_cfg.own_function_code || b[5:4] == CODE_BCAST)
                     && b[3:2] == shadow_cfg.remote_code
                     && (b[1:0] == shadow_cfg.own_device || b[1:0] == CODE_BCAST))
                    ? 3'd2 : 3'd0;
      end
      3'd2: begin
        xor_acc ^= b;
        frame_pos = (b == {1'b0, shadow_cfg.own_track} || b == BROADCAST) ? 3'd3 : 3'd0;
      end
      3'd3: begin
        xor_acc ^= b;
        if (b < shadow_cfg.command_limit) begin
          held_cmd  = b;
          frame_pos = 3'd4;
        end else begin
          frame_pos = 3'd0;
        end
      end
      3'd4, 3'd5: begin
        xor_acc ^= b;
        frame_pos = frame_pos + 3'd1;
      end
      3'd6: begin
        xor_acc ^= b;
        frame_pos = (b == shadow_cfg.tail_value) ? 3'd7 : 3'd0;
      end
      default: begin
        frame_pos = 3'd0;
        if (b == xor_acc || b == CHECK_WILDCARD) begin
          v.frame_ok     = 1'b1;
          v.command_byte = held_cmd;
        end
      end
    endcase
    return v;
  endfunction

  // Occasionally swap a field for a random byte
  function automatic logic [BYTE_W-1:0] perturb(input logic [BYTE_W-1:0] b);
    return ($urandom_range(99) < 6) ? BYTE_W'($urandom_range(255)) : b;
  endfunction

  task automatic push_frame(input logic [BYTE_W-1:0] hdr, addr, trk, cmd, fr0, fr1, tl,
                            input check_mode_e mode);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] chk;
    sum = hdr ^ addr ^ trk ^ cmd ^ fr0 ^ fr1 ^ tl;
    case (mode)
      CHK_EXACT: chk = sum;
      CHK_WILD:  chk = CHECK_WILDCARD;
      default:   chk = sum ^ BYTE_W'($urandom_range(255, 1));
    endcase
    bytes_to_send = {bytes_to_send, hdr, addr, trk, cmd, fr0, fr1, tl, chk};
    bytes_queued += 8;
  endtask

  // One register write per cycle; the caller drops the write enable
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      REG_HEADER:    shadow_cfg.header_value      = val;
      REG_TAIL:      shadow_cfg.tail_value        = val;
      REG_DOWNSTRM:  shadow_cfg.downstream_code   = val[CODE_W-1:0];
      REG_REMOTE:    shadow_cfg.remote_code       = val[CODE_W-1:0];
      REG_OWN_FUNC:  shadow_cfg.own_function_code = val[CODE_W-1:0];
      REG_OWN_DEV:   shadow_cfg.own_device        = val[CODE_W-1:0];
      REG_OWN_TRACK: shadow_cfg.own_track         = val[TRACK_W-1:0];
      default:       shadow_cfg.command_limit     = val;
    endcase
    @(negedge clk_i);
  endtask

  task automatic load_config(input logic [7:0] hdr, tl, dn, rem, fn, dev, trk, lim);
    write_reg(REG_HEADER, hdr);
    write_reg(REG_TAIL, tl);
    write_reg(REG_DOWNSTRM, dn);
    write_reg(REG_REMOTE, rem);
    write_reg(REG_OWN_FUNC, fn);
    write_reg(REG_OWN_DEV, dev);
    write_reg(REG_OWN_TRACK, trk);
    write_reg(REG_CMD_LIMIT, lim);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every byte is through and every verdict has come back
  task automatic settle();
    while (bytes_to_send.size() != 0 || in_valid_i || frame_verdicts.size() != 0)
      @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // Byte driver: hold a stalled beat, otherwise offer the next byte or idle
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (bytes_to_send.size() != 0 && !may_idle()) begin
        in_valid_i <= 1'b1;
        rx_byte_i  <= bytes_to_send.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Predict each accepted byte
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        frame_verdicts.push_back(parse_byte(rx_byte_i));
        bytes_taken++;
      end
    end
  end

  // Receiver stall: random, plus a long hold while plenty of bytes are queued
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (bytes_taken >= next_hold_at && bytes_to_send.size() > 60) begin
      out_stall_i  <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + 400;
    end else begin
      out_stall_i <= rst_ni && may_idle();
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_verdicts.size() == 0) begin
        $error("result beat with no byte outstanding: frame_ok %0d, command_byte 0x%02h",
               frame_ok_o, command_byte_o);
        fail_count++;
      end else begin
        want = frame_verdicts.pop_front();
        if (frame_ok_o !== want.frame_ok) begin
          $error("frame_ok: expected %0d, got %0d", want.frame_ok, frame_ok_o);
          fail_count++;
        end
        if (command_byte_o !== want.command_byte) begin
          $error("command_byte: expected 0x%02h, got 0x%02h",
                 want.command_byte, command_byte_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] cfg_vals [8];
    logic [7:0] lim;
    int         phase_start;
    int         roll;
    check_mode_e mode;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset registers: command limit zero, so an all-zero frame dies at the command
    bytes_to_send = {bytes_to_send, 8'h00, 8'h00, 8'h00, 8'h00};
    settle();

    // Directed frames
    load_config(8'hA5, 8'h5A, 8'd2, 8'd1, 8'd3, 8'd1, 8'h45, 8'h80);
    // own function and device, top command below limit, extreme free bytes
    push_frame(8'hA5, 8'hB5, 8'h45, 8'h7F, 8'h00, 8'hFF, 8'h5A, CHK_EXACT);
    // broadcast function, device and track with the wildcard checksum
    push_frame(8'hA5, 8'h84, 8'h00, 8'h00, 8'hAA, 8'h55, 8'h5A, CHK_WILD);
    // address equal to the header value fails and is not taken as a new header
    push_frame(8'hA5, 8'hA5, 8'h45, 8'h10, 8'h20, 8'h30, 8'h5A, CHK_BAD);
    // track byte with bit 7 set, then a frame left open across a register change
    bytes_to_send = {bytes_to_send, 8'hA5, 8'hB5, 8'hC5, 8'hA5, 8'hB5};
    settle();

    // Random phases, extremes first
    for (int p = 0; p < 7; p++) begin
      foreach (cfg_vals[i]) cfg_vals[i] = 8'($urandom_range(255));
      if (p == 0) begin
        foreach (cfg_vals[i]) cfg_vals[i] = 8'hFF;
      end else if (p == 1) begin
        foreach (cfg_vals[i]) cfg_vals[i] = 8'h00;
        cfg_vals[7] = 8'h01;
      end else if (p == 2) begin
        cfg_vals[7] = 8'h00;
      end else if (cfg_vals[7] == 8'h00) begin
        cfg_vals[7] = 8'h80;
      end
      load_config(cfg_vals[0], cfg_vals[1], cfg_vals[2], cfg_vals[3],
                  cfg_vals[4], cfg_vals[5], cfg_vals[6], cfg_vals[7]);

      phase_start = bytes_queued;
      while (bytes_queued - phase_start < 160) begin
        roll = $urandom_range(99);
        if (roll < 70) begin
          lim  = shadow_cfg.command_limit;
          roll = $urandom_range(99);
          mode = (roll < 60) ? CHK_EXACT : (roll < 80) ? CHK_WILD : CHK_BAD;
          push_frame(perturb(shadow_cfg.header_value),
                     perturb({shadow_cfg.downstream_code,
                              $urandom_range(1) ? shadow_cfg.own_function_code : CODE_BCAST,
                              shadow_cfg.remote_code,
                              $urandom_range(1) ? shadow_cfg.own_device : CODE_BCAST}),
                     perturb($urandom_range(1) ? {1'b0, shadow_cfg.own_track} : BROADCAST),
                     (lim == 8'h00) ? 8'($urandom_range(255))
                                    : perturb(8'($urandom_range(lim - 1, 0))),
                     8'($urandom_range(255)), 8'($urandom_range(255)),
                     perturb(shadow_cfg.tail_value), mode);
        end else begin
          // line noise between frames
          repeat ($urandom_range(5, 1)) begin
            bytes_to_send.push_back(8'($urandom_range(255)));
            bytes_queued++;
          end
        end
      end
      settle();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
